// File: hw/rtl/periodic_threshold_monitor_assert.svh
// Assertion macros used by the monitor's top-level RTL file.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef PERIODIC_THRESHOLD_MONITOR_ASSERT_SVH
`define PERIODIC_THRESHOLD_MONITOR_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define PTM_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("periodic threshold monitor: check failed");

// The consequence holds in the same cycle as the antecedent.
`define PTM_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("periodic threshold monitor: check failed");

`endif

// File: hw/rtl/ptm_pkg.sv
// ---------------------------------------------------------------------------
// ptm_pkg
// Shared constants, codes and types of the periodic threshold monitor.
// ---------------------------------------------------------------------------
package ptm_pkg;

	// Sizing of the block.
	localparam int CHECKS   = 5;
	localparam int SENSORS  = 64;
	localparam int CHECK_AW = (CHECKS > 1) ? $clog2(CHECKS) : 1;
	localparam int SMP_AW   = 6;
	localparam int SMP_W    = 32;
	localparam int COUNT_W  = 20;
	localparam int SLEEP_W  = 10;
	localparam int CFG_IW   = 3;
	localparam int CFG_W    = 63;

	localparam logic [SLEEP_W-1:0] MAX_SLEEP = SLEEP_W'(1000);

	// Command codes.
	localparam logic [1:0] CMD_STORE   = 2'd0;
	localparam logic [1:0] CMD_PASS    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Comparison codes.
	localparam logic [1:0] CMP_LT = 2'd0;
	localparam logic [1:0] CMP_GT = 2'd1;
	localparam logic [1:0] CMP_EQ = 2'd2;

	// Action code that never produces a record.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Record kinds.
	localparam logic REC_ACTION  = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	// One check register, most significant field first.
	typedef struct packed {
		logic signed [SMP_W-1:0] threshold;
		logic [COUNT_W-1:0]      period;
		logic [SMP_AW-1:0]       sensor;
		logic [1:0]              action;
		logic [1:0]              cmp;
		logic                    active;
	} cfg_t;

	// Access to the countdown memory.
	typedef struct packed {
		logic                re;
		logic [CHECK_AW-1:0] raddr;
		logic                we;
		logic [CHECK_AW-1:0] waddr;
		logic [COUNT_W-1:0]  wdata;
	} cnt_req_t;

	// Access to the sample memory.
	typedef struct packed {
		logic                re;
		logic [SMP_AW-1:0]   raddr;
		logic                we;
		logic [SMP_AW-1:0]   waddr;
		logic [SMP_W-1:0]    wdata;
	} smp_req_t;

endpackage

// File: hw/rtl/ptm_if.sv
// ---------------------------------------------------------------------------
// ptm_if
// Valid/ready channels of the monitor: command words in, record words out.
// ---------------------------------------------------------------------------

// Command channel.
interface ptm_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [5:0]         sensor_index;
	logic signed [31:0] sensor_value;

	modport source(output valid, command, sensor_index, sensor_value, input ready);
	modport sink(input valid, command, sensor_index, sensor_value, output ready);
endinterface

// Record channel.
interface ptm_rec_if;
	logic       valid;
	logic       ready;
	logic       record_kind;
	logic [2:0] check_number;
	logic [1:0] action_code;
	logic [9:0] next_sleep;
	logic       last;

	modport source(output valid, record_kind, check_number, action_code, next_sleep, last,
		input ready);
	modport sink(input valid, record_kind, check_number, action_code, next_sleep, last,
		output ready);
endinterface

// File: hw/rtl/periodic_threshold_monitor.sv
// ---------------------------------------------------------------------------
// periodic_threshold_monitor
// Fault monitor over five configured threshold checks with countdowns.
// ---------------------------------------------------------------------------
// Usage:
// The cmd channel takes one command word at a time: store a sensor sample,
// run a pass, or restart all countdowns. Check registers are to be written
// through cfg_we / cfg_index / cfg_data while the block is idle; it is not enforced.
// A store leaves cmd.ready high, so the next word can follow in the next
// cycle. A restart holds cmd.ready low while it visits the checks in turn,
// since each countdown is written through the single write port of its memory.
// A pass visits the checks in order: an active check takes a read step
// (read countdown and sample) and then an evaluate step (evaluate and write
// back), an inactive check only the read step, and a summary step follows;
// cmd.ready is low throughout and the summary word appears as it rises again.
// Each triggered action appears as a word on the rec channel, and the pass
// ends with a summary word carrying next_sleep and last.
// Each record is visible once loaded into the output register. When rec is
// stalled, the output register holds its word and the pass waits at the
// next record; cmd.ready stays low until the pass has issued its summary.
// Reset clears the check registers, countdowns, sleep time and all samples;
// the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
`include "periodic_threshold_monitor_assert.svh"

module periodic_threshold_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	ptm_cmd_if.sink                      cmd,
	ptm_rec_if.source                    rec,
	input  logic                         cfg_we,
	input  logic [ptm_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ptm_pkg::CFG_W-1:0]    cfg_data
);

	ptm_pkg::cnt_req_t             cnt_req;
	ptm_pkg::smp_req_t             smp_req;
	logic [ptm_pkg::COUNT_W-1:0]   cnt_rdata;
	logic [ptm_pkg::SMP_W-1:0]     smp_rdata;

	// Countdown store.
	ptm_cnt_mem u_cnt_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cnt_req),
		.rdata  (cnt_rdata)
	);

	// Sample store.
	ptm_smp_mem u_smp_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (smp_req),
		.rdata  (smp_rdata)
	);

	// Command sequencer and output register.
	ptm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rec       (rec),
		.cnt_req   (cnt_req),
		.cnt_rdata (cnt_rdata),
		.smp_req   (smp_req),
		.smp_rdata (smp_rdata)
	);

	// Countdowns change only while a pass or restart is in progress.
	`PTM_ASSERT_IMPLY(a_idle_no_cnt_write, cmd.ready, !cnt_req.we)
	// Read and write-back of the countdown memory never share a cycle.
	`PTM_ASSERT_ALWAYS(a_cnt_no_overlap, !(cnt_req.we && cnt_req.re))
	// Samples are written only by an accepted store command.
	`PTM_ASSERT_IMPLY(a_smp_write_on_accept, smp_req.we, cmd.valid && cmd.ready)
	// Action words never close a pass.
	`PTM_ASSERT_IMPLY(a_action_not_last,
		rec.valid && (rec.record_kind == ptm_pkg::REC_ACTION), !rec.last)

endmodule

// File: hw/rtl/ptm_cnt_mem.sv
// ---------------------------------------------------------------------------
// ptm_cnt_mem
// Countdown memory: one write and one read port, registered read data.
// Entries never written since reset read as zero.
// ---------------------------------------------------------------------------
module ptm_cnt_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptm_pkg::cnt_req_t              req,
	output logic [ptm_pkg::COUNT_W-1:0]    rdata
);

	logic [ptm_pkg::COUNT_W-1:0] mem [ptm_pkg::CHECKS];
	logic [ptm_pkg::CHECKS-1:0]  valid_q;
	logic [ptm_pkg::COUNT_W-1:0] rdata_q;
	logic                        rvld_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// Written flags, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: hw/rtl/ptm_smp_mem.sv
// ---------------------------------------------------------------------------
// ptm_smp_mem
// Sensor sample memory: one write and one read port, registered read data.
// Slots never written, and slots beyond the sensor count, read as zero.
// ---------------------------------------------------------------------------
module ptm_smp_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptm_pkg::smp_req_t            req,
	output logic [ptm_pkg::SMP_W-1:0]    rdata
);

	logic [ptm_pkg::SMP_W-1:0] mem [ptm_pkg::SENSORS];
	logic [ptm_pkg::SENSORS-1:0] valid_q;
	logic [ptm_pkg::SMP_W-1:0] rdata_q;
	logic                      rvld_q;
	logic                      wr_in_range;
	logic                      rd_in_range;

	assign wr_in_range = int'(req.waddr) < ptm_pkg::SENSORS;
	assign rd_in_range = int'(req.raddr) < ptm_pkg::SENSORS;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (req.we && wr_in_range) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// Written flags, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (req.we && wr_in_range) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvld_q <= rd_in_range && valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: hw/rtl/ptm_seq.sv
// ---------------------------------------------------------------------------
// ptm_seq
// Command sequencer: holds the check registers, reads each check of a pass,
// evaluates the active ones and drives the record output register.
// ---------------------------------------------------------------------------
module ptm_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ptm_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [ptm_pkg::CFG_W-1:0]       cfg_data,
	ptm_cmd_if.sink                         cmd,
	ptm_rec_if.source                       rec,
	output ptm_pkg::cnt_req_t               cnt_req,
	input  logic [ptm_pkg::COUNT_W-1:0]     cnt_rdata,
	output ptm_pkg::smp_req_t               smp_req,
	input  logic [ptm_pkg::SMP_W-1:0]       smp_rdata
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_READ    = 3'd1;
	localparam logic [2:0] ST_EVAL    = 3'd2;
	localparam logic [2:0] ST_SUM     = 3'd3;
	localparam logic [2:0] ST_RESTART = 3'd4;

	logic [2:0]                      state_q;
	logic [ptm_pkg::CHECK_AW-1:0]    k_q;
	logic [ptm_pkg::SLEEP_W-1:0]     sleep_q;
	logic [ptm_pkg::SLEEP_W-1:0]     min_q;
	ptm_pkg::cfg_t                   cfg_q [ptm_pkg::CHECKS];
	ptm_pkg::cfg_t                   cur;

	logic                            ovalid_q;
	logic                            okind_q;
	logic [2:0]                      onum_q;
	logic [1:0]                      oact_q;
	logic [ptm_pkg::SLEEP_W-1:0]     osleep_q;
	logic                            olast_q;

	logic                            accept;
	logic                            can_emit;
	logic                            last_chk;
	logic [ptm_pkg::COUNT_W-1:0]     rc_sub;
	logic                            due;
	logic [ptm_pkg::COUNT_W-1:0]     new_cnt;
	logic                            cand_ok;
	logic                            hit;
	logic                            emit;
	logic                            stall;
	logic                            load_act;
	logic                            load_sum;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign can_emit = !ovalid_q || rec.ready;
	assign last_chk = (k_q == ptm_pkg::CHECK_AW'(ptm_pkg::CHECKS - 1));
	assign cur      = cfg_q[k_q];

	// Check registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptm_pkg::CHECKS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_we && (int'(cfg_index) < ptm_pkg::CHECKS)) begin
			cfg_q[cfg_index[ptm_pkg::CHECK_AW-1:0]] <= ptm_pkg::cfg_t'(cfg_data);
		end
	end

	// Evaluation of the check whose countdown and sample were just read.
	always_comb begin
		rc_sub  = (cnt_rdata > ptm_pkg::COUNT_W'(sleep_q))
			? cnt_rdata - ptm_pkg::COUNT_W'(sleep_q) : '0;
		due     = (rc_sub == '0);
		new_cnt = due ? cur.period : rc_sub;
		cand_ok = (new_cnt != '0) && (new_cnt < ptm_pkg::COUNT_W'(min_q));
		case (cur.cmp)
			ptm_pkg::CMP_LT: hit = $signed(smp_rdata) < cur.threshold;
			ptm_pkg::CMP_GT: hit = $signed(smp_rdata) > cur.threshold;
			ptm_pkg::CMP_EQ: hit = $signed(smp_rdata) == cur.threshold;
			default:         hit = 1'b0;
		endcase
		emit  = due && hit && (cur.action != ptm_pkg::ACT_UNUSED);
		stall = emit && !can_emit;
	end

	assign load_act = (state_q == ST_EVAL) && emit && can_emit;
	assign load_sum = (state_q == ST_SUM) && can_emit;

	// Memory accesses of the current step.
	always_comb begin
		cnt_req = '0;
		smp_req = '0;
		if (accept && (cmd.command == ptm_pkg::CMD_STORE)) begin
			smp_req.we    = 1'b1;
			smp_req.waddr = cmd.sensor_index;
			smp_req.wdata = cmd.sensor_value;
		end
		if ((state_q == ST_READ) && cur.active) begin
			cnt_req.re    = 1'b1;
			cnt_req.raddr = k_q;
			smp_req.re    = 1'b1;
			smp_req.raddr = cur.sensor;
		end
		if ((state_q == ST_EVAL) && !stall) begin
			cnt_req.we    = 1'b1;
			cnt_req.waddr = k_q;
			cnt_req.wdata = new_cnt;
		end
		if (state_q == ST_RESTART) begin
			cnt_req.we    = 1'b1;
			cnt_req.waddr = k_q;
			cnt_req.wdata = cur.period;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			sleep_q <= '0;
			min_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.command)
							ptm_pkg::CMD_PASS: begin
								k_q     <= '0;
								min_q   <= ptm_pkg::MAX_SLEEP;
								state_q <= ST_READ;
							end
							ptm_pkg::CMD_RESTART: begin
								k_q     <= '0;
								sleep_q <= '0;
								state_q <= ST_RESTART;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (cur.active) begin
						state_q <= ST_EVAL;
					end else if (last_chk) begin
						state_q <= ST_SUM;
					end else begin
						k_q <= k_q + ptm_pkg::CHECK_AW'(1);
					end
				end
				ST_EVAL: begin
					if (!stall) begin
						if (cand_ok) begin
							min_q <= new_cnt[ptm_pkg::SLEEP_W-1:0];
						end
						if (last_chk) begin
							state_q <= ST_SUM;
						end else begin
							k_q     <= k_q + ptm_pkg::CHECK_AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_SUM: begin
					if (can_emit) begin
						sleep_q <= min_q;
						state_q <= ST_IDLE;
					end
				end
				ST_RESTART: begin
					if (last_chk) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + ptm_pkg::CHECK_AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_act || load_sum) begin
			ovalid_q <= 1'b1;
		end else if (rec.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (load_act) begin
			okind_q  <= ptm_pkg::REC_ACTION;
			onum_q   <= 3'(k_q);
			oact_q   <= cur.action;
			osleep_q <= '0;
			olast_q  <= 1'b0;
		end else if (load_sum) begin
			okind_q  <= ptm_pkg::REC_SUMMARY;
			onum_q   <= '0;
			oact_q   <= '0;
			osleep_q <= min_q;
			olast_q  <= 1'b1;
		end
	end

	assign rec.valid        = ovalid_q;
	assign rec.record_kind  = okind_q;
	assign rec.check_number = onum_q;
	assign rec.action_code  = oact_q;
	assign rec.next_sleep   = osleep_q;
	assign rec.last         = olast_q;

endmodule

// File: tb/sv/periodic_threshold_monitor_checker.sv
// ---------------------------------------------------------------------------
// periodic_threshold_monitor_checker
// Watches the command, record and check register ports of the monitor. It
// keeps its own copy of the check registers, countdowns, sleep time and
// sensor samples, works out the records that each accepted command word
// should cause, and compares every accepted record word with the oldest one
// still owed.
// ---------------------------------------------------------------------------
module periodic_threshold_monitor_checker
	import ptm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	ptm_cmd_if                cmd,
	ptm_rec_if                rec,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                records_owed,
	output int                mismatch_count
);

	// One record word as it leaves the block.
	typedef struct packed {
		logic               kind;
		logic [2:0]         check_no;
		logic [1:0]         action;
		logic [SLEEP_W-1:0] sleep_secs;
		logic               last;
	} record_t;

	cfg_t               check_cfg [CHECKS];
	logic [COUNT_W-1:0] countdown [CHECKS];
	logic [SMP_W-1:0]   samples [SENSORS];
	logic [SLEEP_W-1:0] sleep_secs;
	record_t            owed_records [$];

	// Apply one command word to the shadow state and queue the records it causes.
	task automatic apply_command(input logic [1:0] op, input logic [SMP_AW-1:0] slot,
		input logic [SMP_W-1:0] value);
		logic [COUNT_W-1:0]      left;
		logic [COUNT_W-1:0]      soonest;
		logic signed [SMP_W-1:0] sample;
		logic signed [SMP_W-1:0] limit;
		logic                    hit;
		record_t                 entry;
		case (op)
			CMD_STORE: begin
				samples[slot] = value;
			end
			CMD_RESTART: begin
				for (int i = 0; i < CHECKS; i++)
					countdown[i] = check_cfg[i].period;
				sleep_secs = '0;
			end
			CMD_PASS: begin
				soonest = COUNT_W'(MAX_SLEEP);
				for (int i = 0; i < CHECKS; i++) begin
					if (check_cfg[i].active) begin
						// Count down by the last sleep time, stopping at zero.
						if (countdown[i] > COUNT_W'(sleep_secs))
							left = countdown[i] - COUNT_W'(sleep_secs);
						else
							left = '0;
						if (left != '0) begin
							if (left < soonest)
								soonest = left;
							countdown[i] = left;
						end else begin
							// The check is due: reload and compare the sample.
							countdown[i] = check_cfg[i].period;
							if (check_cfg[i].period != '0 && check_cfg[i].period < soonest)
								soonest = check_cfg[i].period;
							sample = samples[check_cfg[i].sensor];
							limit = check_cfg[i].threshold;
							case (check_cfg[i].cmp)
								CMP_LT:  hit = (sample < limit);
								CMP_GT:  hit = (sample > limit);
								CMP_EQ:  hit = (sample == limit);
								default: hit = 1'b0;
							endcase
							if (hit && check_cfg[i].action != ACT_UNUSED) begin
								entry.kind = REC_ACTION;
								entry.check_no = 3'(i);
								entry.action = check_cfg[i].action;
								entry.sleep_secs = '0;
								entry.last = 1'b0;
								owed_records.push_back(entry);
							end
						end
					end
				end
				// The summary closes the pass with the next sleep time.
				sleep_secs = soonest[SLEEP_W-1:0];
				entry.kind = REC_SUMMARY;
				entry.check_no = '0;
				entry.action = '0;
				entry.sleep_secs = sleep_secs;
				entry.last = 1'b1;
				owed_records.push_back(entry);
			end
			default: begin
				// Unknown commands leave everything as it was.
			end
		endcase
	endtask

	// Compare one accepted record word with the oldest owed record.
	task automatic compare_record();
		record_t seen;
		record_t want;
		seen.kind = rec.record_kind;
		seen.check_no = rec.check_number;
		seen.action = rec.action_code;
		seen.sleep_secs = rec.next_sleep;
		seen.last = rec.last;
		if (owed_records.size() == 0) begin
			$display("%0t: unexpected record: expected none, actual kind %0d check %0d",
				$time, seen.kind, seen.check_no,
				" action %0d sleep %0d last %0d", seen.action, seen.sleep_secs, seen.last);
			mismatch_count <= mismatch_count + 1;
		end else begin
			want = owed_records.pop_front();
			if (seen !== want) begin
				$display("%0t: record mismatch: expected kind %0d check %0d action %0d",
					$time, want.kind, want.check_no, want.action,
					" sleep %0d last %0d, actual kind %0d check %0d action %0d",
					want.sleep_secs, want.last, seen.kind, seen.check_no, seen.action,
					" sleep %0d last %0d", seen.sleep_secs, seen.last);
				mismatch_count <= mismatch_count + 1;
			end
		end
	endtask

	// Track the ports edge by edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHECKS; i++) begin
				check_cfg[i] = '0;
				countdown[i] = '0;
			end
			for (int i = 0; i < SENSORS; i++)
				samples[i] = '0;
			sleep_secs = '0;
			owed_records.delete();
			records_owed <= 0;
			mismatch_count <= 0;
		end else begin
			if (cfg_we && cfg_index < CFG_IW'(CHECKS))
				check_cfg[cfg_index] = cfg_t'(cfg_data);
			if (cmd.valid && cmd.ready)
				apply_command(cmd.command, cmd.sensor_index, cmd.sensor_value);
			if (rec.valid && rec.ready)
				compare_record();
			records_owed <= owed_records.size();
		end
	end

endmodule

// File: tb/sv/periodic_threshold_monitor_test.sv
// ---------------------------------------------------------------------------
// periodic_threshold_monitor_test
// Drives the monitor with a directed command sequence and then phases of
// random commands under several check register settings, with random gaps
// on both channels, one long record stall and pauses until all records are
// in. A checker beside the block predicts and compares every record word.
// ---------------------------------------------------------------------------
module periodic_threshold_monitor_test;
	import ptm_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int POOL_SIZE       = 8;
	localparam int SETTLE_CYCLES   = 32;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 2000;

	localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
	localparam logic [1:0]  CMP_NONE      = 2'd3;
	localparam logic [1:0]  ACT_INFO      = 2'd0;
	localparam logic [1:0]  ACT_RESET     = 2'd1;
	localparam logic [1:0]  ACT_POWER_OFF = 2'd2;
	localparam logic [31:0] Q_MIN         = 32'h8000_0000;
	localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              steady;
	logic              hold_off_req;
	int                records_owed;
	int                mismatch_count;
	cfg_t              check_plan [CHECKS];
	logic [31:0]       value_pool [POOL_SIZE];

	ptm_cmd_if cmd_ch();
	ptm_rec_if rec_ch();

	periodic_threshold_monitor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rec       (rec_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	periodic_threshold_monitor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_ch),
		.rec            (rec_ch),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.records_owed   (records_owed),
		.mismatch_count (mismatch_count)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample values: mostly from a pool shared with the thresholds, so that
	// equality and near misses come up often.
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = value_pool[$urandom_range(POOL_SIZE - 1)];
		case ($urandom_range(9))
			0, 1:    v = $urandom();
			2:       v = v + 32'd1;
			3:       v = v - 32'd1;
			default: ;
		endcase
		return v;
	endfunction

	// Sample slots: mostly a handful that the checks read.
	function automatic logic [5:0] pick_slot();
		if ($urandom_range(99) < 75)
			return 6'($urandom_range(7));
		return 6'($urandom_range(63));
	endfunction

	function automatic cfg_t random_check(input bit wide_period);
		cfg_t c;
		c.active = ($urandom_range(99) < 80);
		c.cmp = 2'($urandom_range(3));
		c.action = 2'($urandom_range(3));
		c.sensor = pick_slot();
		c.period = wide_period ? 20'($urandom()) : 20'($urandom_range(12));
		c.threshold = pick_value();
		return c;
	endfunction

	// Write all check registers from check_plan.
	task automatic program_checks();
		for (int k = 0; k < CHECKS; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IW'(k);
			cfg_data <= check_plan[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one command word after an optional random gap; returns once it is
	// accepted, with valid still high.
	task automatic send_word(input logic [1:0] op, input logic [5:0] slot,
		input logic [31:0] value);
		while (!steady && $urandom_range(99) < 33) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.sensor_index <= slot;
		cmd_ch.sensor_value <= value;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			send_word(CMD_STORE, pick_slot(), pick_value());
		else if (pick < 85)
			send_word(CMD_PASS, 6'($urandom()), $urandom());
		else if (pick < 95)
			send_word(CMD_RESTART, 6'($urandom()), $urandom());
		else
			send_word(CMD_UNKNOWN, 6'($urandom()), $urandom());
	endtask

	// Stop offering, wait for every owed record, then let the block settle.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (records_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Record side: random stalls, one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rec_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				rec_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			rec_ch.ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog on cycles in which no word moves on either channel.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rec_ch.valid && rec_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		steady <= 1'b0;
		hold_off_req <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_STORE;
		cmd_ch.sensor_index <= '0;
		cmd_ch.sensor_value <= '0;
		value_pool = '{Q_MIN, Q_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
			$urandom(), $urandom()};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: every comparison and action, field extremes, a zero
		// period, an unknown comparison, an unknown action and an unknown command.
		check_plan[0] = '{threshold: Q_MAX, period: 20'd1, sensor: 6'd0,
			action: ACT_INFO, cmp: CMP_LT, active: 1'b1};
		check_plan[1] = '{threshold: Q_MIN, period: 20'hFFFFF, sensor: 6'd63,
			action: ACT_RESET, cmp: CMP_GT, active: 1'b1};
		check_plan[2] = '{threshold: 32'd0, period: 20'd0, sensor: 6'd5,
			action: ACT_POWER_OFF, cmp: CMP_EQ, active: 1'b1};
		check_plan[3] = '{threshold: 32'd0, period: 20'd3, sensor: 6'd0,
			action: ACT_INFO, cmp: CMP_NONE, active: 1'b1};
		check_plan[4] = '{threshold: Q_MAX, period: 20'd2, sensor: 6'd0,
			action: ACT_UNUSED, cmp: CMP_LT, active: 1'b1};
		program_checks();
		send_word(CMD_STORE, 6'd0, Q_MIN);
		send_word(CMD_STORE, 6'd63, Q_MAX);
		send_word(CMD_STORE, 6'd5, 32'd0);
		repeat (3) send_word(CMD_PASS, '0, '0);
		send_word(CMD_RESTART, '1, '1);
		send_word(CMD_PASS, '0, '0);
		send_word(CMD_STORE, 6'd5, 32'hFFFF_FFFF);
		send_word(CMD_UNKNOWN, 6'h2A, 32'h5555_AAAA);
		repeat (3) send_word(CMD_PASS, '0, '0);
		send_word(CMD_STORE, 6'd0, Q_MAX);
		repeat (2) send_word(CMD_PASS, '0, '0);
		wait_idle();

		// Random phases: all registers cleared, all set, then random settings.
		// Countdowns carry over between settings, so newly active checks meet
		// stale counts below the sleep time.
		for (int phase = 0; phase < PHASES; phase++) begin
			value_pool[6] = $urandom();
			value_pool[7] = $urandom();
			for (int k = 0; k < CHECKS; k++) begin
				if (phase == 0)
					check_plan[k] = '0;
				else if (phase == 1)
					check_plan[k] = '1;
				else
					check_plan[k] = random_check(phase == 6 || $urandom_range(3) == 0);
			end
			program_checks();
			steady <= (phase == 3);
			if (phase == 4)
				hold_off_req <= 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random_item();
				if (phase == 5 && n == ITEMS_PER_PHASE / 2)
					wait_idle();
			end
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
